// ----- rtl/core/circle_octant_rasterizer_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the circle octant rasterizer
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_OCTANT_RASTERIZER_MACROS_SVH
`define CIRCLE_OCTANT_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define COR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("circle rasterizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define COR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("circle rasterizer check failed");

`else

`define COR_ASSERT_IMP(lbl, ante, cons)
`define COR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/cor_pkg.sv -----
// ---------------------------------------------------------------------------
// Circle octant rasterizer package
// Shared constants and types for the rasterizer core.
// ---------------------------------------------------------------------------
package cor_pkg;

  // Default coordinate width of center and octant point.
  localparam int COORD_BITS_DEF = 11;

  // Pixel words are always this wide, two's complement.
  localparam int PIX_BITS = 13;
  localparam int OCT_BITS = 3;

  // Result tdata: pixel_x, pixel_y, octant, padded to whole bytes.
  localparam int OUT_FIELD_BITS = 2 * PIX_BITS + OCT_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Last of the eight symmetric copies.
  localparam logic [OCT_BITS-1:0] OCT_LAST = 3'd7;

  // Input kind codes.
  localparam logic KIND_START    = 1'b0;
  localparam logic KIND_CONTINUE = 1'b1;

  // Step direction of the midpoint walk.
  typedef enum logic [1:0] {
    MOVE_H,
    MOVE_D,
    MOVE_V
  } move_t;

  // Status of the pixel emitter seen by the top level.
  typedef struct packed {
    logic busy;     // a step transaction is being emitted
    logic at_last;  // the result being loaded now is the step's last one
  } emit_stat_t;

endpackage

// ----- rtl/core/cor_stepper.sv -----
// ---------------------------------------------------------------------------
// Circle rasterizer stepper
// Holds the walk state and computes the current octant point and the next
// midpoint step for each accepted input transaction.
// ---------------------------------------------------------------------------
module cor_stepper
  import cor_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         kind,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [COORD_BITS-2:0]        radius,
  output logic signed [COORD_BITS-1:0] pt_x,
  output logic signed [COORD_BITS-1:0] pt_y,
  output logic [COORD_BITS-1:0]        pt_cx,
  output logic [COORD_BITS-1:0]        pt_cy,
  output logic                         pt_fin
);

  localparam int EW = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] pos_x_r, pos_y_r;
  logic signed [EW-1:0]         err_r;
  logic [COORD_BITS-1:0]        cen_x_r, cen_y_r;

  logic signed [COORD_BITS-1:0] x_nxt, y_nxt;
  logic signed [EW-1:0]         err_nxt;

  logic                         load;
  logic signed [EW-1:0]         cur_d, xe, ye;
  logic signed [EW:0]           sum_dy, dif_dx;
  logic                         dy_nonpos, dx_nonpos;
  move_t                        move;

  always_comb begin
    load  = (kind == KIND_START);
    pt_x  = load ? '0 : pos_x_r;
    pt_y  = load ? {1'b0, radius} : pos_y_r;
    cur_d = load ? (EW'(2) - EW'({radius, 1'b0})) : err_r;
    pt_cx = load ? center_x : cen_x_r;
    pt_cy = load ? center_y : cen_y_r;

    pt_fin = (pt_y < pt_x);

    xe = {{3{pt_x[COORD_BITS-1]}}, pt_x};
    ye = {{3{pt_y[COORD_BITS-1]}}, pt_y};

    // Midpoint tests: 2(d+y)-1 <= 0 is d+y <= 0, likewise for d-x.
    sum_dy    = {cur_d[EW-1], cur_d} + {ye[EW-1], ye};
    dif_dx    = {cur_d[EW-1], cur_d} - {xe[EW-1], xe};
    dy_nonpos = sum_dy[EW] || (sum_dy == '0);
    dx_nonpos = dif_dx[EW] || (dif_dx == '0);

    priority if (cur_d[EW-1]) begin
      move = dy_nonpos ? MOVE_H : MOVE_D;
    end else if (cur_d != '0) begin
      move = dx_nonpos ? MOVE_D : MOVE_V;
    end else begin
      move = MOVE_D;
    end

    // The update of d uses the already moved x and y, folded in here.
    unique case (move)
      MOVE_H: begin
        x_nxt   = pt_x + COORD_BITS'(1);
        y_nxt   = pt_y;
        err_nxt = cur_d + (xe <<< 1) + EW'(3);
      end
      MOVE_V: begin
        x_nxt   = pt_x;
        y_nxt   = pt_y - COORD_BITS'(1);
        err_nxt = cur_d - (ye <<< 1) + EW'(3);
      end
      default: begin
        x_nxt   = pt_x + COORD_BITS'(1);
        y_nxt   = pt_y - COORD_BITS'(1);
        err_nxt = cur_d + (xe <<< 1) - (ye <<< 1) + EW'(6);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      err_r   <= '0;
      cen_x_r <= '0;
      cen_y_r <= '0;
    end else if (accept) begin
      cen_x_r <= pt_cx;
      cen_y_r <= pt_cy;
      // A finished circle keeps its state, but a start still loads it.
      if (!pt_fin) begin
        pos_x_r <= x_nxt;
        pos_y_r <= y_nxt;
        err_r   <= err_nxt;
      end else begin
        pos_x_r <= pt_x;
        pos_y_r <= pt_y;
        err_r   <= cur_d;
      end
    end
  end

endmodule

// ----- rtl/core/cor_emitter.sv -----
// ---------------------------------------------------------------------------
// Circle rasterizer pixel emitter
// Holds one step's octant point and sends its eight symmetric pixels, or a
// single finished marker, through a registered output stage.
// ---------------------------------------------------------------------------
module cor_emitter
  import cor_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_load,
  output logic                         job_ready,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  input  logic [COORD_BITS-1:0]        pt_cx,
  input  logic [COORD_BITS-1:0]        pt_cy,
  input  logic                         pt_fin,
  output emit_stat_t                   stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PIX_BITS-1:0]          out_pixel_x,
  output logic [PIX_BITS-1:0]          out_pixel_y,
  output logic [OCT_BITS-1:0]          out_octant,
  output logic                         out_pixel_valid,
  output logic                         out_finished,
  output logic                         out_last
);

  localparam int SW = (COORD_BITS + 2 > PIX_BITS) ? COORD_BITS + 2 : PIX_BITS;

  logic                         job_valid_r;
  logic signed [COORD_BITS-1:0] job_x_r, job_y_r;
  logic [COORD_BITS-1:0]        job_cx_r, job_cy_r;
  logic                         job_fin_r;
  logic [OCT_BITS-1:0]          idx_r;

  logic                         out_valid_r;
  logic [PIX_BITS-1:0]          px_r, py_r;
  logic [OCT_BITS-1:0]          oct_r;
  logic                         pv_r, fin_r, last_r;

  logic                         out_free, emit, job_last;
  logic signed [COORD_BITS-1:0] term_a, term_b;
  logic [SW-1:0]                ext_a, ext_b, cx_ext, cy_ext, sum_x, sum_y;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    emit      = job_valid_r && out_free;
    job_last  = job_fin_r || (idx_r == OCT_LAST);
    job_ready = !job_valid_r || (emit && job_last);

    stat.busy    = job_valid_r;
    stat.at_last = emit && job_last;

    // Octant bit 2 swaps the roles of x and y; bits 0 and 1 mirror them.
    term_a = idx_r[2] ? job_y_r : job_x_r;
    term_b = idx_r[2] ? job_x_r : job_y_r;
    ext_a  = {{(SW-COORD_BITS){term_a[COORD_BITS-1]}}, term_a};
    ext_b  = {{(SW-COORD_BITS){term_b[COORD_BITS-1]}}, term_b};
    cx_ext = {{(SW-COORD_BITS){1'b0}}, job_cx_r};
    cy_ext = {{(SW-COORD_BITS){1'b0}}, job_cy_r};
    sum_x  = idx_r[0] ? (cx_ext - ext_a) : (cx_ext + ext_a);
    sum_y  = idx_r[1] ? (cy_ext - ext_b) : (cy_ext + ext_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (job_load) begin
      job_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (emit) begin
      idx_r <= idx_r + OCT_BITS'(1);
      if (job_last) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_x_r   <= pt_x;
      job_y_r   <= pt_y;
      job_cx_r  <= pt_cx;
      job_cy_r  <= pt_cy;
      job_fin_r <= pt_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (job_fin_r) begin
        px_r   <= '0;
        py_r   <= '0;
        oct_r  <= '0;
        pv_r   <= 1'b0;
        fin_r  <= 1'b1;
        last_r <= 1'b1;
      end else begin
        px_r   <= sum_x[PIX_BITS-1:0];
        py_r   <= sum_y[PIX_BITS-1:0];
        oct_r  <= idx_r;
        pv_r   <= 1'b1;
        fin_r  <= 1'b0;
        last_r <= (idx_r == OCT_LAST);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_octant      = oct_r;
  assign out_pixel_valid = pv_r;
  assign out_finished    = fin_r;
  assign out_last        = last_r;

endmodule

// ----- rtl/core/circle_octant_rasterizer.sv -----
// ---------------------------------------------------------------------------
// Circle octant rasterizer
// Bresenham midpoint circle walk with eight-way symmetric pixel output.
// ---------------------------------------------------------------------------
// A transaction with tuser low loads a center and radius and takes the first
// step; one with tuser high takes the next step. While the walk is inside
// its octant each step yields eight pixel transactions, one per cycle while
// the result stream does not stall, the last with tlast; after that each step
// yields one finished marker. The step logic sits between the walk registers
// and the emitter's point register, so a new input transaction is taken in
// the same cycle that the emitter loads the last result of the previous one.
// Each result passes through the emitter's point register and then its
// single output register before it shows on out_tvalid.

`include "circle_octant_rasterizer_macros.svh"

module circle_octant_rasterizer
  import cor_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_BITS   = ((3 * COORD_BITS - 1 + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // Input stream.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_BITS-1:0]       in_tdata,   // center_x, center_y, radius
  input  logic                     in_tuser,   // kind
  // Result stream.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // pixel_x, pixel_y, octant
  output logic [1:0]               out_tuser,  // pixel_valid, finished
  output logic                     out_tlast
);

  logic                         in_accept;
  logic signed [COORD_BITS-1:0] pt_x, pt_y;
  logic [COORD_BITS-1:0]        pt_cx, pt_cy;
  logic                         pt_fin;
  emit_stat_t                   stat;
  logic [PIX_BITS-1:0]          pixel_x, pixel_y;
  logic [OCT_BITS-1:0]          octant;
  logic                         pixel_valid, finished;

  assign in_accept = in_tvalid && in_tready;

  cor_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .kind     (in_tuser),
    .center_x (in_tdata[COORD_BITS-1:0]),
    .center_y (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius   (in_tdata[3*COORD_BITS-2:2*COORD_BITS]),
    .pt_x     (pt_x),
    .pt_y     (pt_y),
    .pt_cx    (pt_cx),
    .pt_cy    (pt_cy),
    .pt_fin   (pt_fin)
  );

  cor_emitter #(
    .COORD_BITS (COORD_BITS)
  ) u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_load        (in_accept),
    .job_ready       (in_tready),
    .pt_x            (pt_x),
    .pt_y            (pt_y),
    .pt_cx           (pt_cx),
    .pt_cy           (pt_cy),
    .pt_fin          (pt_fin),
    .stat            (stat),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_pixel_x     (pixel_x),
    .out_pixel_y     (pixel_y),
    .out_octant      (octant),
    .out_pixel_valid (pixel_valid),
    .out_finished    (finished),
    .out_last        (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}}, octant, pixel_y, pixel_x};
  assign out_tuser = {finished, pixel_valid};

  // An accepted transaction is always being emitted in the next cycle.
  `COR_ASSERT_NXT(a_accept_busy, in_accept, stat.busy)

  // A new input is only taken when the emitter is idle or finishing a step.
  `COR_ASSERT_IMP(a_ready_gap, in_tready && stat.busy, stat.at_last)

  // A finished marker is a lone, pixel-free last result.
  `COR_ASSERT_IMP(a_fin_marker, out_tvalid && finished, out_tlast && !pixel_valid)

  // Among pixel results, tlast marks exactly the eighth octant.
  `COR_ASSERT_IMP(a_pix_last, out_tvalid && pixel_valid, out_tlast == (octant == OCT_LAST))

endmodule

// ----- tb/tb_circle_octant_rasterizer.sv -----
// ---------------------------------------------------------------------------
// Circle octant rasterizer testbench
// Drives start and step transactions into the rasterizer and checks every
// result transaction against a midpoint circle walk kept in the testbench.
// Directed cases cover the zero state after reset, the extreme centers and
// radii, and full walks. Random walks then run under three idling patterns
// on the input and result streams.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cor_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int IN_W        = ((3 * COORD_W - 1 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [PIX_BITS-1:0] px;
    logic [PIX_BITS-1:0] py;
    logic [OCT_BITS-1:0] oct;
    logic                pix_valid;
    logic                finished;
    logic                is_last;
  } pixel_rec_t;

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     in_tvalid  = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata   = '0;
  logic                     in_tuser   = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [1:0]               out_tuser;
  logic                     out_tlast;

  // Walk state of the circle being rasterized.
  logic signed [COORD_W-1:0] walk_x   = '0;
  logic signed [COORD_W-1:0] walk_y   = '0;
  logic signed [COORD_W+2:0] walk_err = '0;
  logic [COORD_W-1:0]        ctr_x    = '0;
  logic [COORD_W-1:0]        ctr_y    = '0;

  pixel_rec_t expected_pixels[$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int items_sent      = 0;
  int circles_started = 0;
  int pixels_seen     = 0;
  int markers_seen    = 0;
  int error_count     = 0;
  int cycle_count     = 0;
  int move_hits[3]    = '{0, 0, 0};

  circle_octant_rasterizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected.",
               cycle_count, expected_pixels.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Works out the results of one accepted input transaction and advances
  // the walk state.
  task automatic rasterize_step(input logic kind, input logic [COORD_W-1:0] cx,
                                input logic [COORD_W-1:0] cy,
                                input logic [COORD_W-2:0] r);
    int x, y, d, c_col, c_row, a, b;
    move_t mv;
    pixel_rec_t rec;
    if (kind == KIND_START) begin
      ctr_x    = cx;
      ctr_y    = cy;
      walk_x   = '0;
      walk_y   = COORD_W'(r);
      walk_err = (COORD_W + 3)'(2 - 2 * int'(r));
    end
    x = int'(walk_x);
    y = int'(walk_y);
    d = int'(walk_err);
    if (y < x) begin
      rec = '0;
      rec.finished = 1'b1;
      rec.is_last  = 1'b1;
      expected_pixels.push_back(rec);
      return;
    end
    c_col = int'(ctr_x);
    c_row = int'(ctr_y);
    // The first four copies reflect (x, y), the last four (y, x).
    for (int k = 0; k < 8; k++) begin
      a = (k < 4) ? x : y;
      b = (k < 4) ? y : x;
      rec.px        = PIX_BITS'(k[0] ? c_col - a : c_col + a);
      rec.py        = PIX_BITS'(k[1] ? c_row - b : c_row + b);
      rec.oct       = OCT_BITS'(k);
      rec.pix_valid = 1'b1;
      rec.finished  = 1'b0;
      rec.is_last   = (OCT_BITS'(k) == OCT_LAST);
      expected_pixels.push_back(rec);
    end
    if (d < 0) mv = (2 * (d + y) - 1 <= 0) ? MOVE_H : MOVE_D;
    else if (d > 0) mv = (2 * (d - x) - 1 <= 0) ? MOVE_D : MOVE_V;
    else mv = MOVE_D;
    move_hits[mv]++;
    case (mv)
      MOVE_H: begin
        x = x + 1;
        d = d + 2 * x + 1;
      end
      MOVE_D: begin
        x = x + 1;
        y = y - 1;
        d = d + 2 * x - 2 * y + 2;
      end
      default: begin
        y = y - 1;
        d = d - 2 * y + 1;
      end
    endcase
    walk_x   = COORD_W'(x);
    walk_y   = COORD_W'(y);
    walk_err = (COORD_W + 3)'(d);
  endtask

  task automatic send_item(input logic kind, input logic [COORD_W-1:0] cx,
                           input logic [COORD_W-1:0] cy,
                           input logic [COORD_W-2:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {r, cy, cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rasterize_step(kind, cx, cy, r);
    items_sent++;
  endtask

  // Step transactions carry random payload, which the block must ignore.
  task automatic send_continue();
    send_item(KIND_CONTINUE, COORD_W'($urandom), COORD_W'($urandom),
              (COORD_W - 1)'($urandom));
  endtask

  // Starts a circle and steps it until it finishes or the step budget runs
  // out, then adds some steps that should only yield finished markers.
  task automatic run_circle(input logic [COORD_W-1:0] cx,
                            input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-2:0] r, input int max_steps,
                            input int extra_markers);
    int steps;
    send_item(KIND_START, cx, cy, r);
    circles_started++;
    steps = 0;
    while (steps < max_steps && walk_y >= walk_x) begin
      send_continue();
      steps++;
    end
    repeat (extra_markers) send_continue();
  endtask

  always @(posedge clk) begin
    pixel_rec_t got, want;
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got.px        = out_tdata[PIX_BITS-1:0];
      got.py        = out_tdata[2*PIX_BITS-1:PIX_BITS];
      got.oct       = out_tdata[2*PIX_BITS+OCT_BITS-1:2*PIX_BITS];
      got.pix_valid = out_tuser[0];
      got.finished  = out_tuser[1];
      got.is_last   = out_tlast;
      if (got.finished) markers_seen++;
      else pixels_seen++;
      if (expected_pixels.size() == 0) begin
        error_count++;
        if (error_count <= SHOW_LIMIT)
          $display("%0t: unexpected result x=%0d y=%0d oct=%0d pv=%b fin=%b last=%b",
                   $realtime, $signed(got.px), $signed(got.py), got.oct,
                   got.pix_valid, got.finished, got.is_last);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= SHOW_LIMIT) begin
            $display("%0t: mismatch exp x=%0d y=%0d oct=%0d pv=%b fin=%b last=%b",
                     $realtime, $signed(want.px), $signed(want.py), want.oct,
                     want.pix_valid, want.finished, want.is_last);
            $display("%0t:          got x=%0d y=%0d oct=%0d pv=%b fin=%b last=%b",
                     $realtime, $signed(got.px), $signed(got.py), got.oct,
                     got.pix_valid, got.finished, got.is_last);
          end
        end
      end
    end
  end

  // The reset state is a walk at the origin with point (0, 0) and error term zero.
  task automatic test_step_after_reset();
    send_item(KIND_CONTINUE, '1, '1, '1);
    send_item(KIND_CONTINUE, '0, '0, '0);
  endtask

  task automatic test_extreme_circles();
    run_circle('0, '0, '0, 4, 1);
    run_circle('1, '1, '1, 2, 0);
    run_circle('0, '0, '1, 1, 0);
    run_circle('1, '0, (COORD_W - 1)'(1), 4, 1);
    run_circle('0, '1, (COORD_W - 1)'(10), 20, 1);
  endtask

  task automatic test_random_walks(input int n_items, input int s_pct, input int r_pct);
    int stop_at, pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70)
        run_circle(COORD_W'($urandom), COORD_W'($urandom),
                   (COORD_W - 1)'($urandom_range(40)), 100, $urandom_range(2));
      else if (pick < 82)
        run_circle(COORD_W'($urandom), COORD_W'($urandom), (COORD_W - 1)'($urandom),
                   $urandom_range(1, 6), 0);
      else if (pick < 92)
        send_continue();
      else
        run_circle(COORD_W'($urandom), COORD_W'($urandom), (COORD_W - 1)'($urandom), 0, 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 15;
    recv_idle_pct = 83;
    test_step_after_reset();
    test_extreme_circles();
    test_random_walks(140, 15, 83);
    test_random_walks(140, 83, 15);
    test_random_walks(140, 0, 0);
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d transactions over %0d circles; checked %0d pixels and %0d markers.",
             items_sent, circles_started, pixels_seen, markers_seen);
    $display("Walk moves taken: %0d horizontal, %0d diagonal, %0d vertical.",
             move_hits[MOVE_H], move_hits[MOVE_D], move_hits[MOVE_V]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
